@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the bounded set RTL.
// Depends on nothing; included by bounded_set_with_rank_select, which checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BSRS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error("%m failed");

// Check that a condition implies another in the next cycle.
`define BSRS_ASSERT_NEXT(lbl, clk, rst_n, cond, nxt) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) else $error("%m failed");

`endif

@@ rtl/core/bsrs_pkg.sv @@
// Package for the bounded set with rank select: command codes, words, token control.
// Depends on nothing.
`default_nettype none
package bsrs_pkg;

  localparam int MAX_ENTRIES_DEF = 32;
  localparam int KEY_BITS_DEF    = 32;
  localparam int KEY_W           = 32;
  localparam int RANK_W          = 5;
  localparam int COUNT_W         = 6;

  typedef enum logic [1:0] {
    CMD_INSERT   = 2'd0,
    CMD_ERASE    = 2'd1,
    CMD_CONTAINS = 2'd2,
    CMD_GET      = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                cmd;
    logic [KEY_W-1:0]    key;
    logic [RANK_W-1:0]   rank;
  } in_word_t;

  typedef struct packed {
    logic                ok;
    logic [KEY_W-1:0]    item;
    logic [COUNT_W-1:0]  count;
  } out_word_t;

  typedef struct packed {
    logic vld;
    cmd_t cmd;
    logic hit;
    logic act;
    logic done;
  } tok_ctl_t;

endpackage
`default_nettype wire

@@ rtl/core/bsrs_cell.sv @@
// One cell of the sorted chain: holds one key and passes the command token on.
// Depends on bsrs_pkg.
`default_nettype none
module bsrs_cell #(
  parameter int KW  = 32,
  parameter int CW  = 6,
  parameter int IDX = 0
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [CW-1:0]             cnt,
  input  wire logic [KW-1:0]             nbr_ent,
  input  wire bsrs_pkg::tok_ctl_t        ctl_in,
  input  wire logic [KW-1:0]             key_in,
  input  wire logic [bsrs_pkg::RANK_W-1:0] rank_in,
  input  wire logic [KW-1:0]             item_in,
  output bsrs_pkg::tok_ctl_t             ctl_out,
  output logic [KW-1:0]                  key_out,
  output logic [bsrs_pkg::RANK_W-1:0]    rank_out,
  output logic [KW-1:0]                  item_out,
  output logic [KW-1:0]                  ent
);
  import bsrs_pkg::*;

  logic [KW-1:0]     ent_r, ent_nxt;
  tok_ctl_t          ctl_r, ctl_nxt;
  logic [KW-1:0]     key_r, item_r, item_nxt;
  logic [RANK_W-1:0] rank_r;
  logic              live, at_end, rank_hit;

  assign live     = 32'(cnt) > 32'(IDX);
  assign at_end   = 32'(cnt) == 32'(IDX);
  assign rank_hit = 32'(rank_in) == 32'(IDX);

  always_comb begin
    ent_nxt  = ent_r;
    ctl_nxt  = ctl_in;
    item_nxt = item_in;
    if (ctl_in.vld) begin
      unique case (ctl_in.cmd)
        CMD_INSERT: begin
          if (live) begin
            if (ctl_in.act) begin
              ent_nxt  = item_in;
              item_nxt = ent_r;
            end else if (!ctl_in.hit && !ctl_in.done) begin
              if (ent_r == key_in) begin
                ctl_nxt.hit = 1'b1;
              end else if (ent_r < key_in) begin
                ent_nxt      = key_in;
                item_nxt     = ent_r;
                ctl_nxt.act  = 1'b1;
                ctl_nxt.done = 1'b1;
              end
            end
          end else if (at_end) begin
            if (ctl_in.act) begin
              ent_nxt     = item_in;
              ctl_nxt.act = 1'b0;
            end else if (!ctl_in.hit && !ctl_in.done) begin
              ent_nxt      = key_in;
              ctl_nxt.done = 1'b1;
            end
          end
        end
        CMD_ERASE: begin
          if (live && (ctl_in.act || ent_r == key_in)) begin
            ent_nxt     = nbr_ent;
            ctl_nxt.act = 1'b1;
            ctl_nxt.hit = 1'b1;
          end
        end
        CMD_CONTAINS: begin
          if (live && ent_r == key_in) begin
            ctl_nxt.hit = 1'b1;
          end
        end
        CMD_GET: begin
          if (live && rank_hit) begin
            ctl_nxt.hit = 1'b1;
            item_nxt    = ent_r;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ent_r  <= ent_nxt;
    key_r  <= key_in;
    rank_r <= rank_in;
    item_r <= item_nxt;
  end

  assign ctl_out  = ctl_r;
  assign key_out  = key_r;
  assign rank_out = rank_r;
  assign item_out = item_r;
  assign ent      = ent_r;

endmodule
`default_nettype wire

@@ rtl/core/bounded_set_with_rank_select.sv @@
// Top level of the bounded set with rank select: command port, cell chain, count.
// Depends on bsrs_pkg, bsrs_cell and assert_macros.svh.
//
// Usage: present a command word on in_word with start high; it is taken at a
// rising edge where busy is low. busy stays high while the command token walks
// the chain of MAX_ENTRIES cells, one cell per cycle. Keys sit in the cells in
// descending order, so insert, erase, contains and get by rank all finish in
// one pass: insert shifts smaller keys right, erase pulls later keys left.
// The token leaves the last cell into a result register; the result is shown
// on out_word for one cycle with out_valid high. busy drops at the edge that
// registers the result, so the next word can be taken while it is shown.
// A new command is taken only once the previous token has left the chain.
// out_word.count is the number of keys held after the command.
// Reset empties the set and drops any command in flight; the receiver has no
// stall and must take each result in the cycle it is shown.
`default_nettype none
module bounded_set_with_rank_select #(
  parameter int MAX_ENTRIES = bsrs_pkg::MAX_ENTRIES_DEF,
  parameter int KEY_BITS    = bsrs_pkg::KEY_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire bsrs_pkg::in_word_t  in_word,
  output logic                     out_valid,
  output bsrs_pkg::out_word_t      out_word
);
  import bsrs_pkg::*;
  `include "assert_macros.svh"

  localparam int KW = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int N  = MAX_ENTRIES;

  tok_ctl_t          tk_ctl  [N+1];
  logic [KW-1:0]     tk_key  [N+1];
  logic [RANK_W-1:0] tk_rank [N+1];
  logic [KW-1:0]     tk_item [N+1];
  logic [KW-1:0]     ent     [N];
  logic [N:0]        tk_vld;

  tok_ctl_t          t0_ctl_r, t0_ctl_nxt;
  logic [KW-1:0]     t0_key_r;
  logic [RANK_W-1:0] t0_rank_r;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              busy_r, busy_nxt;
  logic              out_valid_r;
  out_word_t         out_word_r, out_word_nxt;
  logic              accept;
  tok_ctl_t          fin;

  assign accept = start && !busy_r;
  assign fin    = tk_ctl[N];

  always_comb begin
    t0_ctl_nxt      = '0;
    t0_ctl_nxt.vld  = accept;
    t0_ctl_nxt.cmd  = in_word.cmd;
    t0_ctl_nxt.hit  = (in_word.cmd == CMD_INSERT) && (32'(cnt_r) == 32'(N));
  end

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (fin.vld) begin
      busy_nxt = 1'b0;
      if (fin.cmd == CMD_INSERT && fin.done) begin
        cnt_nxt = cnt_r + CW'(1);
      end else if (fin.cmd == CMD_ERASE && fin.hit) begin
        cnt_nxt = cnt_r - CW'(1);
      end
    end
  end

  always_comb begin
    out_word_nxt       = '0;
    out_word_nxt.ok    = (fin.cmd == CMD_INSERT) ? fin.done : fin.hit;
    out_word_nxt.count = COUNT_W'(cnt_nxt);
    if (fin.cmd == CMD_GET && fin.hit) begin
      out_word_nxt.item = KEY_W'(tk_item[N]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t0_ctl_r    <= '0;
      cnt_r       <= '0;
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      t0_ctl_r    <= t0_ctl_nxt;
      cnt_r       <= cnt_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= fin.vld;
    end
  end

  always_ff @(posedge clk) begin
    t0_key_r   <= in_word.key[KW-1:0];
    t0_rank_r  <= in_word.rank;
    out_word_r <= out_word_nxt;
  end

  assign tk_ctl[0]  = t0_ctl_r;
  assign tk_key[0]  = t0_key_r;
  assign tk_rank[0] = t0_rank_r;
  assign tk_item[0] = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [KW-1:0] nbr;
    if (i == N - 1) begin : g_last
      assign nbr = ent[i];
    end else begin : g_mid
      assign nbr = ent[i+1];
    end
    bsrs_cell #(
      .KW  (KW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cnt      (cnt_r),
      .nbr_ent  (nbr),
      .ctl_in   (tk_ctl[i]),
      .key_in   (tk_key[i]),
      .rank_in  (tk_rank[i]),
      .item_in  (tk_item[i]),
      .ctl_out  (tk_ctl[i+1]),
      .key_out  (tk_key[i+1]),
      .rank_out (tk_rank[i+1]),
      .item_out (tk_item[i+1]),
      .ent      (ent[i])
    );
  end

  for (genvar i = 0; i <= N; i++) begin : g_vld
    assign tk_vld[i] = tk_ctl[i].vld;
  end

  assign busy      = busy_r;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  `BSRS_ASSERT(a_one_token, clk, rst_n, $onehot0(tk_vld))
  `BSRS_ASSERT(a_token_busy, clk, rst_n, (tk_vld == '0) || busy_r)
  `BSRS_ASSERT(a_cnt_bound, clk, rst_n, 32'(cnt_r) <= 32'(N))
  `BSRS_ASSERT(a_out_idle, clk, rst_n, !out_valid_r || !busy_r)
  `BSRS_ASSERT_NEXT(a_accept_busy, clk, rst_n, accept, busy_r && t0_ctl_r.vld)

endmodule
`default_nettype wire
